[design/cooldown_cell_pick_sequencer_assert.svh]
// assertion macros for the cooldown cell pick sequencer checker
// needs nothing else; included by the checker file only
`ifndef COOLDOWN_CELL_PICK_SEQUENCER_ASSERT_SVH
`define COOLDOWN_CELL_PICK_SEQUENCER_ASSERT_SVH

// consequent checked in the cycle after the antecedent
`define CCPS_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("cooldown sequencer check failed");

// consequent checked in the same cycle as the antecedent
`define CCPS_ASSERT_SAME(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("cooldown sequencer check failed");

`endif

[design/ccps_pkg.sv]
// shared constants, types and helper functions of the cooldown cell pick sequencer
// no dependencies; imported by every module of the block
package ccps_pkg;

  // grid size
  localparam int CELLS_X    = 8;
  localparam int CELLS_Y    = 4;
  localparam int CELLS_Z    = 4;
  localparam int GRID_CELLS = CELLS_X * CELLS_Y * CELLS_Z;

  localparam int XW     = $clog2(CELLS_X);
  localparam int YW     = $clog2(CELLS_Y);
  localparam int ZW     = $clog2(CELLS_Z);
  localparam int GRID_W = $clog2(GRID_CELLS);

  // fixed field widths
  localparam int START_X_W = 3;
  localparam int START_Y_W = 2;
  localparam int START_Z_W = 2;
  localparam int CELL_W    = 7;
  localparam int PICK_W    = 7;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 6;
  localparam int PC_W      = 8;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_COOLDOWN = '0;
  localparam logic [COUNT_W-1:0] COOLDOWN_RESET = 6'd12;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PICK  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_STARTED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_PICKED  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NONE    = 2'd3;

  // command from the sequencer to the cell store
  typedef struct packed {
    logic              clear;  // drop all counts and visited marks
    logic              decr;   // count down every nonzero count
    logic              arm;    // load idx with the cooldown value
    logic              visit;  // mark idx visited
    logic              snap;   // register the blocked vector
    logic [GRID_W-1:0] idx;
  } store_cmd_t;

  // linear cell index from coordinates
  function automatic logic [GRID_W-1:0] cell_lin(input logic [XW-1:0] x,
                                                 input logic [YW-1:0] y,
                                                 input logic [ZW-1:0] z);
    logic [GRID_W-1:0] zy;
    zy = GRID_W'(z) * GRID_W'(CELLS_Y) + GRID_W'(y);
    return zy * GRID_W'(CELLS_X) + GRID_W'(x);
  endfunction

  // wrapped neighbor coordinate, d in 0..2 stands for -1..+1
  function automatic int wrap_nbr(input int v, input int d, input int n);
    int r;
    r = v + d - 1;
    if (r < 0) r = r + n;
    if (r >= n) r = r - n;
    return r;
  endfunction

  // reduce a narrow start coordinate into 0..n-1 (n at least 3, value at most 7)
  function automatic logic [3:0] mod_small(input logic [3:0] v, input logic [4:0] n);
    logic [4:0] r;
    r = {1'b0, v};
    for (int i = 0; i < 2; i++) begin
      if (r >= n) r = r - n;
    end
    return r[3:0];
  endfunction

endpackage

[design/ccps_cell_store.sv]
// per-cell cooldown counters, visited marks and registered neighborhood-blocked vector
// depends on ccps_pkg
module ccps_cell_store (
  input  logic                          clk,
  input  logic                          rst,
  input  ccps_pkg::store_cmd_t          cmd,
  input  logic [ccps_pkg::COUNT_W-1:0]  arm_value,
  input  logic [ccps_pkg::GRID_W-1:0]   probe,
  output logic                          probe_free
);
  import ccps_pkg::*;

  logic [COUNT_W-1:0]    counts [GRID_CELLS];
  logic [GRID_CELLS-1:0] visited;
  logic [GRID_CELLS-1:0] busy;
  logic [GRID_CELLS-1:0] blocked;
  logic [GRID_CELLS-1:0] blocked_next;

  always_comb begin
    for (int i = 0; i < GRID_CELLS; i++) begin
      busy[i] = (counts[i] != '0);
    end
  end

  // a cell is blocked when any of its 27 wrapped neighbors is still counting
  always_comb begin
    blocked_next = '0;
    for (int z = 0; z < CELLS_Z; z++) begin
      for (int y = 0; y < CELLS_Y; y++) begin
        for (int x = 0; x < CELLS_X; x++) begin
          for (int dz = 0; dz < 3; dz++) begin
            for (int dy = 0; dy < 3; dy++) begin
              for (int dx = 0; dx < 3; dx++) begin
                blocked_next[(z * CELLS_Y + y) * CELLS_X + x] =
                  blocked_next[(z * CELLS_Y + y) * CELLS_X + x] |
                  busy[(wrap_nbr(z, dz, CELLS_Z) * CELLS_Y + wrap_nbr(y, dy, CELLS_Y))
                       * CELLS_X + wrap_nbr(x, dx, CELLS_X)];
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GRID_CELLS; i++) begin
        counts[i] <= '0;
      end
      visited <= '0;
      blocked <= '0;
    end else begin
      for (int i = 0; i < GRID_CELLS; i++) begin
        if (cmd.arm && cmd.idx == GRID_W'(i)) begin
          counts[i] <= arm_value;
        end else if (cmd.clear) begin
          counts[i] <= '0;
        end else if (cmd.decr && counts[i] != '0) begin
          counts[i] <= counts[i] - 1'b1;
        end
        if (cmd.visit && cmd.idx == GRID_W'(i)) begin
          visited[i] <= 1'b1;
        end else if (cmd.clear) begin
          visited[i] <= 1'b0;
        end
      end
      if (cmd.snap) begin
        blocked <= blocked_next;
      end
    end
  end

  assign probe_free = !visited[probe] && !blocked[probe];

endmodule

[design/cooldown_cell_pick_sequencer.sv]
// top level of the cooldown cell pick sequencer: handshake, register port, scan sequencer
// depends on ccps_pkg and ccps_cell_store
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid / in_stall  | kind, start_x, start_y, start_z
//  out     | output    | out_valid / out_stall| cell_index, pick_number, status
//  cfg     | input     | psel/penable/pwrite  | paddr, pwdata, prdata (pready high)
//
// a start beat, or a pick beat after the sequence has ended, goes from idle straight to emit
// a live pick beat goes through scan, which probes 2..GRID_CELLS candidates,
//   one candidate per cycle from the cell store; the first
//   candidate is the current cell, which is always visited
// in_stall is high from the cycle after a beat is taken until its result sits
//   in the output register; a result waiting there does not block the next beat
// synchronous reset: counts, visited marks, position and output valid cleared,
//   sequence marked ended, cooldown_steps back to 12
module cooldown_cell_pick_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  // input beats
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            kind,
  input  logic [ccps_pkg::START_X_W-1:0]  start_x,
  input  logic [ccps_pkg::START_Y_W-1:0]  start_y,
  input  logic [ccps_pkg::START_Z_W-1:0]  start_z,
  // result beats
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ccps_pkg::CELL_W-1:0]     cell_index,
  output logic [ccps_pkg::PICK_W-1:0]     pick_number,
  output logic [ccps_pkg::STATUS_W-1:0]   status,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ccps_pkg::ADDR_W-1:0]     paddr,
  input  logic [ccps_pkg::DATA_W-1:0]     pwdata,
  output logic [ccps_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import ccps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state;

  // sequence position
  logic [XW-1:0]       cur_x;
  logic [YW-1:0]       cur_y;
  logic [ZW-1:0]       cur_z;
  logic [PC_W-1:0]     pick_count;
  logic                seq_ended;

  // scan offsets, x innermost
  logic [XW-1:0]       dx;
  logic [YW-1:0]       dy;
  logic [ZW-1:0]       dz;

  // pending result
  logic [CELL_W-1:0]   res_cell;
  logic [PICK_W-1:0]   res_num;
  logic [STATUS_W-1:0] res_status;

  logic [COUNT_W-1:0]  cooldown_steps;

  logic                in_take;
  logic                cfg_write;
  logic                cfg_hit;

  // start coordinates reduced into the grid
  logic [XW-1:0]       st_x;
  logic [YW-1:0]       st_y;
  logic [ZW-1:0]       st_z;
  logic [GRID_W-1:0]   st_cell;

  // current candidate
  logic [XW:0]         sum_x;
  logic [YW:0]         sum_y;
  logic [ZW:0]         sum_z;
  logic [XW-1:0]       nx;
  logic [YW-1:0]       ny;
  logic [ZW-1:0]       nz;
  logic [GRID_W-1:0]   cand;
  logic                cand_free;
  logic                last_offset;
  logic                last_pick;

  store_cmd_t          cmd;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // register port
  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[ADDR_W-1:2] == REG_COOLDOWN);
  assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
  assign prdata    = cfg_hit ? DATA_W'(cooldown_steps) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown_steps <= COOLDOWN_RESET;
    end else if (cfg_write) begin
      cooldown_steps <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    st_x    = XW'(mod_small(4'(start_x), 5'(CELLS_X)));
    st_y    = YW'(mod_small(4'(start_y), 5'(CELLS_Y)));
    st_z    = ZW'(mod_small(4'(start_z), 5'(CELLS_Z)));
    st_cell = cell_lin(st_x, st_y, st_z);
  end

  // candidate = current cell plus offset, wrapped per axis
  always_comb begin
    sum_x = {1'b0, cur_x} + {1'b0, dx};
    sum_y = {1'b0, cur_y} + {1'b0, dy};
    sum_z = {1'b0, cur_z} + {1'b0, dz};
    if (sum_x >= (XW+1)'(CELLS_X)) sum_x = sum_x - (XW+1)'(CELLS_X);
    if (sum_y >= (YW+1)'(CELLS_Y)) sum_y = sum_y - (YW+1)'(CELLS_Y);
    if (sum_z >= (ZW+1)'(CELLS_Z)) sum_z = sum_z - (ZW+1)'(CELLS_Z);
    nx   = sum_x[XW-1:0];
    ny   = sum_y[YW-1:0];
    nz   = sum_z[ZW-1:0];
    cand = cell_lin(nx, ny, nz);
  end

  assign last_offset = (dx == XW'(CELLS_X - 1)) && (dy == YW'(CELLS_Y - 1)) &&
                       (dz == ZW'(CELLS_Z - 1));
  // this pick fills the grid
  assign last_pick   = ({1'b0, pick_count} + 1'b1) >= (PC_W+1)'(GRID_CELLS);

  // store commands
  always_comb begin
    cmd = '0;
    if (state == ST_IDLE && in_take) begin
      if (kind == KIND_START) begin
        cmd.clear = 1'b1;
        cmd.arm   = 1'b1;
        cmd.visit = 1'b1;
        cmd.idx   = st_cell;
      end else if (!seq_ended) begin
        cmd.snap = 1'b1;
      end
    end else if (state == ST_SCAN && cand_free) begin
      cmd.decr  = 1'b1;
      cmd.visit = 1'b1;
      cmd.arm   = !last_pick;
      cmd.idx   = cand;
    end
  end

  ccps_cell_store u_store (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .arm_value  (cooldown_steps),
    .probe      (cand),
    .probe_free (cand_free)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur_x      <= '0;
      cur_y      <= '0;
      cur_z      <= '0;
      pick_count <= '0;
      seq_ended  <= 1'b1;
      dx         <= '0;
      dy         <= '0;
      dz         <= '0;
      out_valid  <= 1'b0;
    end else begin
      // output register drains independently of the sequencer
      if (state == ST_EMIT && (!out_valid || !out_stall)) begin
        out_valid   <= 1'b1;
        cell_index  <= res_cell;
        pick_number <= res_num;
        status      <= res_status;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (kind == KIND_START) begin
              cur_x      <= st_x;
              cur_y      <= st_y;
              cur_z      <= st_z;
              pick_count <= PC_W'(1);
              seq_ended  <= 1'b0;
              res_cell   <= CELL_W'(st_cell);
              res_num    <= '0;
              res_status <= STAT_STARTED;
              state      <= ST_EMIT;
            end else if (seq_ended) begin
              res_cell   <= '0;
              res_num    <= PICK_W'(pick_count);
              res_status <= STAT_NONE;
              state      <= ST_EMIT;
            end else begin
              // blocked vector is captured this edge, scan starts next cycle
              dx    <= '0;
              dy    <= '0;
              dz    <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (cand_free) begin
            cur_x      <= nx;
            cur_y      <= ny;
            cur_z      <= nz;
            pick_count <= pick_count + 1'b1;
            res_cell   <= CELL_W'(cand);
            res_num    <= PICK_W'(pick_count);
            res_status <= last_pick ? STAT_DONE : STAT_PICKED;
            if (last_pick) seq_ended <= 1'b1;
            state      <= ST_EMIT;
          end else if (last_offset) begin
            // nothing feasible: sequence ends, store untouched
            seq_ended  <= 1'b1;
            res_cell   <= '0;
            res_num    <= PICK_W'(pick_count);
            res_status <= STAT_NONE;
            state      <= ST_EMIT;
          end else if (dx == XW'(CELLS_X - 1)) begin
            dx <= '0;
            if (dy == YW'(CELLS_Y - 1)) begin
              dy <= '0;
              dz <= dz + 1'b1;
            end else begin
              dy <= dy + 1'b1;
            end
          end else begin
            dx <= dx + 1'b1;
          end
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[design/ccps_checker.sv]
// port-level checker for the cooldown cell pick sequencer, bound to the top level
// depends on ccps_pkg and cooldown_cell_pick_sequencer_assert.svh
`include "cooldown_cell_pick_sequencer_assert.svh"

module ccps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [ccps_pkg::CELL_W-1:0]     cell_index,
  input logic [ccps_pkg::PICK_W-1:0]     pick_number,
  input logic [ccps_pkg::STATUS_W-1:0]   status
);
  import ccps_pkg::*;

  // a stalled result beat holds
  `CCPS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(cell_index) && $stable(pick_number) && $stable(status))

  // one beat at a time: the cycle after a take the input is stalled
  `CCPS_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)

  // nothing leaves right after reset
  `CCPS_ASSERT_SAME(a_quiet_after_reset, clk, 1'b0, $past(rst), !out_valid)

  // a failed pick reports no cell
  `CCPS_ASSERT_SAME(a_none_no_cell, clk, rst, out_valid && status == STAT_NONE,
    cell_index == '0)

endmodule

bind cooldown_cell_pick_sequencer ccps_checker u_ccps_checker (.*);

[test/cooldown_cell_pick_sequencer_tb.sv]
// self-checking bench for the cooldown cell pick sequencer: directed rows, then
// random start/pick runs under several cooldown settings and idle patterns
// depends on ccps_pkg and the cooldown_cell_pick_sequencer top level
`timescale 1ns / 100ps

module cooldown_cell_pick_sequencer_tb;
  import ccps_pkg::*;

  // one result beat
  typedef struct packed {
    logic [CELL_W-1:0]   cidx;
    logic [PICK_W-1:0]   num;
    logic [STATUS_W-1:0] stat;
  } pick_rec_t;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic                 kind;
    logic [START_X_W-1:0] x;
    logic [START_Y_W-1:0] y;
    logic [START_Z_W-1:0] z;
    logic                 typed;
    logic [CELL_W-1:0]    cidx;
    logic [PICK_W-1:0]    num;
    logic [STATUS_W-1:0]  stat;
  } stim_row_t;

  localparam int PLAN_ROWS = 24;
  localparam int SEG_BEATS = 175;                 // beats per cooldown setting
  localparam int HOLD_CYCLES = 300;               // long receiver hold-off
  localparam int SETTLE_CYCLES = 2 * GRID_CELLS + 8;
  localparam logic [ADDR_W-1:0] COOLDOWN_ADDR = {REG_COOLDOWN, 2'b00};

  // directed table, walked in order with the reset cooldown of 12
  localparam stim_row_t PLAN [PLAN_ROWS] = '{
    // pick before any start: sequence counts as ended, nothing picked yet
    '{KIND_PICK,  3'd0, 2'd0, 2'd0, 1'b1, 7'd0,   7'd0, STAT_NONE},
    '{KIND_PICK,  3'd7, 2'd3, 2'd3, 1'b1, 7'd0,   7'd0, STAT_NONE},
    // lowest corner start
    '{KIND_START, 3'd0, 2'd0, 2'd0, 1'b1, 7'd0,   7'd0, STAT_STARTED},
    '{KIND_PICK,  3'd0, 2'd0, 2'd0, 1'b0, 7'd0,   7'd0, STAT_NONE},
    '{KIND_PICK,  3'd7, 2'd3, 2'd3, 1'b0, 7'd0,   7'd0, STAT_NONE},
    '{KIND_PICK,  3'd0, 2'd0, 2'd0, 1'b0, 7'd0,   7'd0, STAT_NONE},
    // highest corner start, the scan wraps on every axis from here
    '{KIND_START, 3'd7, 2'd3, 2'd3, 1'b1, 7'd127, 7'd0, STAT_STARTED},
    '{KIND_PICK,  3'd0, 2'd0, 2'd0, 1'b0, 7'd0,   7'd0, STAT_NONE},
    '{KIND_PICK,  3'd0, 2'd0, 2'd0, 1'b0, 7'd0,   7'd0, STAT_NONE},
    '{KIND_PICK,  3'd0, 2'd0, 2'd0, 1'b0, 7'd0,   7'd0, STAT_NONE},
    '{KIND_PICK,  3'd0, 2'd0, 2'd0, 1'b0, 7'd0,   7'd0, STAT_NONE},
    '{KIND_PICK,  3'd0, 2'd0, 2'd0, 1'b0, 7'd0,   7'd0, STAT_NONE},
    // mid-grid start, then enough picks to run into a blocked grid
    '{KIND_START, 3'd5, 2'd2, 2'd1, 1'b1, 7'd53,  7'd0, STAT_STARTED},
    '{KIND_PICK,  3'd1, 2'd1, 2'd1, 1'b0, 7'd0,   7'd0, STAT_NONE},
    '{KIND_PICK,  3'd2, 2'd2, 2'd2, 1'b0, 7'd0,   7'd0, STAT_NONE},
    '{KIND_PICK,  3'd3, 2'd3, 2'd3, 1'b0, 7'd0,   7'd0, STAT_NONE},
    '{KIND_PICK,  3'd4, 2'd0, 2'd0, 1'b0, 7'd0,   7'd0, STAT_NONE},
    '{KIND_PICK,  3'd5, 2'd1, 2'd1, 1'b0, 7'd0,   7'd0, STAT_NONE},
    '{KIND_PICK,  3'd6, 2'd2, 2'd2, 1'b0, 7'd0,   7'd0, STAT_NONE},
    '{KIND_PICK,  3'd7, 2'd3, 2'd3, 1'b0, 7'd0,   7'd0, STAT_NONE},
    // restart while a sequence is live
    '{KIND_START, 3'd2, 2'd1, 2'd2, 1'b1, 7'd74,  7'd0, STAT_STARTED},
    '{KIND_PICK,  3'd0, 2'd0, 2'd0, 1'b0, 7'd0,   7'd0, STAT_NONE},
    '{KIND_START, 3'd0, 2'd3, 2'd0, 1'b1, 7'd24,  7'd0, STAT_STARTED},
    '{KIND_PICK,  3'd0, 2'd0, 2'd0, 1'b0, 7'd0,   7'd0, STAT_NONE}
  };

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports, all known from time zero
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 kind = KIND_START;
  logic [START_X_W-1:0] start_x = '0;
  logic [START_Y_W-1:0] start_y = '0;
  logic [START_Z_W-1:0] start_z = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CELL_W-1:0]    cell_index;
  logic [PICK_W-1:0]    pick_number;
  logic [STATUS_W-1:0]  status;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  cooldown_cell_pick_sequencer DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .start_x     (start_x),
    .start_y     (start_y),
    .start_z     (start_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cell_index  (cell_index),
    .pick_number (pick_number),
    .status      (status),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // ---------------------------------------------------------------------------
  // sequencer mirror: cooldown counts, visited marks, position, run state
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] cool_left [GRID_CELLS];
  bit                 seen_cell [GRID_CELLS];
  int                 at_cell = 0;
  logic [PC_W-1:0]    next_num = '0;
  bit                 run_over = 1'b1;         // ended until the first start
  logic [COUNT_W-1:0] hold_steps = COOLDOWN_RESET;

  pick_rec_t due_picks [$];                    // results still owed by the block

  // run statistics and error count
  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int started_seen = 0;
  int picked_seen = 0;
  int done_seen = 0;
  int none_seen = 0;
  int cfg_writes = 0;

  // idle odds in percent, changed per phase
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  bit hold_req = 1'b0;

  function automatic int cell_at(input int x, input int y, input int z);
    return (z * CELLS_Y + y) * CELLS_X + x;
  endfunction

  // true when none of the 27 wrapped neighbors is still cooling down
  function automatic bit hood_idle(input int x, input int y, input int z);
    int k;
    for (int dz = -1; dz <= 1; dz++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++) begin
          k = cell_at((x + dx + CELLS_X) % CELLS_X, (y + dy + CELLS_Y) % CELLS_Y,
                      (z + dz + CELLS_Z) % CELLS_Z);
          if (cool_left[k] != '0) return 1'b0;
        end
    return 1'b1;
  endfunction

  // advance the mirror by one accepted beat and return the result it owes
  function automatic pick_rec_t next_pick(input logic k, input logic [START_X_W-1:0] sx,
                                          input logic [START_Y_W-1:0] sy,
                                          input logic [START_Z_W-1:0] sz);
    pick_rec_t r;
    int cx, cy, cz, nx, ny, nz, t;
    bit found;
    found = 1'b0;
    if (k == KIND_START) begin
      for (int i = 0; i < GRID_CELLS; i++) begin
        cool_left[i] = '0;
        seen_cell[i] = 1'b0;
      end
      at_cell = cell_at(sx % CELLS_X, sy % CELLS_Y, sz % CELLS_Z);
      seen_cell[at_cell] = 1'b1;
      cool_left[at_cell] = hold_steps;
      next_num = PC_W'(1);
      run_over = 1'b0;
      r.cidx = CELL_W'(at_cell);
      r.num = '0;
      r.stat = STAT_STARTED;
      return r;
    end
    if (!run_over) begin
      cx = at_cell % CELLS_X;
      cy = (at_cell / CELLS_X) % CELLS_Y;
      cz = (at_cell / (CELLS_X * CELLS_Y)) % CELLS_Z;
      // offset order from the current cell, x innermost; first fit wins
      for (int dz = 0; dz < CELLS_Z && !found; dz++)
        for (int dy = 0; dy < CELLS_Y && !found; dy++)
          for (int dx = 0; dx < CELLS_X && !found; dx++) begin
            nx = (cx + dx) % CELLS_X;
            ny = (cy + dy) % CELLS_Y;
            nz = (cz + dz) % CELLS_Z;
            t = cell_at(nx, ny, nz);
            if (!seen_cell[t] && hood_idle(nx, ny, nz)) found = 1'b1;
          end
      if (found) begin
        for (int i = 0; i < GRID_CELLS; i++)
          if (cool_left[i] != '0) cool_left[i] = cool_left[i] - 1'b1;
        seen_cell[t] = 1'b1;
        at_cell = t;
        r.cidx = CELL_W'(t);
        r.num = next_num[PICK_W-1:0];
        // the last cell of the grid ends the run and is left unarmed
        if (int'(next_num) + 1 >= GRID_CELLS) begin
          run_over = 1'b1;
          r.stat = STAT_DONE;
        end else begin
          cool_left[t] = hold_steps;
          r.stat = STAT_PICKED;
        end
        next_num = next_num + 1'b1;
        return r;
      end
      run_over = 1'b1;
    end
    // ended sequence or nothing feasible
    r.cidx = '0;
    r.num = next_num[PICK_W-1:0];
    r.stat = STAT_NONE;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("error at %0t ns: %s", $time, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // input side: offer one beat, hold it until taken, then book its result
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic k, input logic [START_X_W-1:0] sx,
                           input logic [START_Y_W-1:0] sy,
                           input logic [START_Z_W-1:0] sz,
                           input bit use_typed, input pick_rec_t typed_rec);
    pick_rec_t got;
    // random gap before the beat; valid stays high when there is none
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    start_x  <= sx;
    start_y  <= sy;
    start_z  <= sz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = next_pick(k, sx, sy, sz);
    due_picks.push_back(use_typed ? typed_rec : got);
    beats_sent++;
  endtask

  task automatic send_random(input logic k);
    send_beat(k, START_X_W'($urandom_range(7)), START_Y_W'($urandom_range(3)),
              START_Z_W'($urandom_range(3)), 1'b0, '0);
  endtask

  // stop offering and wait until every owed result has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_picks.size() != 0) @(posedge clk);
  endtask

  // a well-formed run: start, then picks until it ends or the cap is hit,
  // sometimes a couple of extra picks into the ended sequence
  task automatic run_sequence();
    int cap;
    int n;
    send_random(KIND_START);
    cap = ($urandom_range(3) == 0) ? GRID_CELLS + 2 : $urandom_range(1, 40);
    n = 0;
    while (n < cap && !run_over) begin
      send_random(KIND_PICK);
      n++;
    end
    if (run_over) repeat ($urandom_range(2)) send_random(KIND_PICK);
  endtask

  // ---------------------------------------------------------------------------
  // register port: setup then access; the write lands on the access edge
  // ---------------------------------------------------------------------------
  task automatic write_cooldown(input logic [COUNT_W-1:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= COOLDOWN_ADDR;
    // upper data bits are junk the register must drop
    pwdata  <= {DATA_W'($urandom) & ~DATA_W'({COUNT_W{1'b1}})} | DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    hold_steps = v;
    cfg_writes++;
  endtask

  task automatic check_cooldown();
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= COOLDOWN_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[COUNT_W-1:0] !== hold_steps)
      flag_mismatch($sformatf("cooldown readback %0d, wrote %0d",
                              prdata[COUNT_W-1:0], hold_steps));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : stall_gen
    int hold_left;
    bit hold_done;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // every taken result is matched against the oldest one owed
  always @(posedge clk) begin : result_check
    pick_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_picks.size() == 0) begin
        flag_mismatch($sformatf("unexpected result cell %0d pick %0d status %0d",
                                cell_index, pick_number, status));
      end else begin
        want = due_picks.pop_front();
        results_seen++;
        if (cell_index !== want.cidx)
          flag_mismatch($sformatf("result %0d cell_index %0d, want %0d",
                                  results_seen, cell_index, want.cidx));
        if (pick_number !== want.num)
          flag_mismatch($sformatf("result %0d pick_number %0d, want %0d",
                                  results_seen, pick_number, want.num));
        if (status !== want.stat)
          flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                  results_seen, status, want.stat));
        case (want.stat)
          STAT_STARTED: started_seen++;
          STAT_PICKED:  picked_seen++;
          STAT_DONE:    done_seen++;
          default:      none_seen++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int steps_plan [9];
    int seg_end;
    bit held;
    bit paused;
    pick_rec_t row_rec;

    held = 1'b0;
    paused = 1'b0;
    // extremes first, zero blocks nothing and lets a run cover the whole grid
    steps_plan = '{63, 0, 1, $urandom_range(1, 63), 12, 0, 1, $urandom_range(2, 62), 63};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_cooldown();                            // reset value

    // directed rows, no idling
    for (int r = 0; r < PLAN_ROWS; r++) begin
      row_rec.cidx = PLAN[r].cidx;
      row_rec.num  = PLAN[r].num;
      row_rec.stat = PLAN[r].stat;
      send_beat(PLAN[r].kind, PLAN[r].x, PLAN[r].y, PLAN[r].z, PLAN[r].typed, row_rec);
    end

    // random phases: receiver idles, then sender idles, then neither
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 86 : 0;
      rcv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 24 : 0;
      for (int sg = 0; sg < 3; sg++) begin
        // register writes only with the block idle
        drain();
        repeat (4) @(posedge clk);
        write_cooldown(COUNT_W'(steps_plan[ph * 3 + sg]));
        check_cooldown();
        seg_end = beats_sent + SEG_BEATS;
        while (beats_sent < seg_end) begin
          // receiver holds off while beats keep coming, so the block backs up
          if (ph == 2 && sg == 0 && !held && beats_sent + SEG_BEATS / 2 > seg_end) begin
            hold_req = 1'b1;
            held = 1'b1;
          end
          // sender waits for every owed result before going on
          if (ph == 1 && sg == 1 && !paused && beats_sent + SEG_BEATS / 2 > seg_end) begin
            drain();
            paused = 1'b1;
          end
          if ($urandom_range(99) < 88) begin
            run_sequence();
          end else begin
            send_random($urandom_range(1) ? KIND_PICK : KIND_START);
          end
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_picks.size() != 0)
      flag_mismatch($sformatf("%0d results never came out", due_picks.size()));

    $display("covered %0d beats in, %0d results out under %0d cooldown writes",
             beats_sent, results_seen, cfg_writes);
    $display("  started %0d, picked %0d, grid completed %0d, no cell or ended %0d",
             started_seen, picked_seen, done_seen, none_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : watchdog
    #20_000_000;
    $display("timeout with %0d results still owed", due_picks.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
